// ===== hdl/pfc_pkg.sv =====
// shared types, constants and helpers for the pixel format converter
package pfc_pkg;

  typedef enum logic [1:0] {
    FMT_L    = 2'd0,
    FMT_LA   = 2'd1,
    FMT_RGB  = 2'd2,
    FMT_RGBA = 2'd3
  } fmt_t;

  // configuration register indexes
  localparam int unsigned NUM_REGS  = 2;
  localparam int unsigned REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TARGET = REG_IDX_W'(1);

  localparam fmt_t SOURCE_RESET = FMT_RGB;
  localparam fmt_t TARGET_RESET = FMT_RGBA;

  // bt.709 luma weights, q0.16, summing to one
  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  localparam logic [7:0] FULL_ALPHA = 8'd255;

  localparam int unsigned NUM_STAGES = 4;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // truncating divide by 255, exact for any 16-bit product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== hdl/pixel_format_convert.sv =====
// pixel format converter top level: config registers and four-stage datapath
// Converts one pixel of 8-bit channels per word between L, LA, RGB and RGBA.
// One word is accepted every clock while the output side keeps up. The four
// register stages are: the luma and alpha products, the luma sum and the
// divides by 255 of the colour products, the product of luma and alpha, and
// the final divide and format select into the output register. A stall at
// the output backs up stage by stage, so empty slots keep filling and
// in_ready drops only when all four stages hold a word. Formats are sampled
// per word as it enters, and are meant to be written only while the pipeline
// is empty. When source and target match, same_format_error is raised and
// the pixel goes through unchanged; channels the target does not use read as
// zero.
module pixel_format_convert (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [pfc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [1:0]                    cfg_data,
  // input pixel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_chan0,
  input  logic [7:0] in_chan1,
  input  logic [7:0] in_chan2,
  input  logic [7:0] in_chan3,
  // output pixel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_chan0,
  output logic [7:0] out_chan1,
  output logic [7:0] out_chan2,
  output logic [7:0] out_chan3,
  output logic [2:0] channel_count,
  output logic       same_format_error
);

  // configuration registers
  pfc_pkg::fmt_t source_format;
  pfc_pkg::fmt_t target_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfc_pkg::SOURCE_RESET;
      target_format <= pfc_pkg::TARGET_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pfc_pkg::REG_SOURCE) begin
        source_format <= pfc_pkg::fmt_t'(cfg_data);
      end
      if (cfg_index == pfc_pkg::REG_TARGET) begin
        target_format <= pfc_pkg::fmt_t'(cfg_data);
      end
    end
  end

  // handshake and stage enables
  pfc_pkg::pipe_ctrl_t ctrl;

  pfc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  // alpha sits in chan1 for la and in chan3 otherwise
  logic [7:0] in_alpha;
  assign in_alpha = (source_format == pfc_pkg::FMT_LA) ? in_chan1 : in_chan3;

  // stage 1: all first-level products
  pfc_pkg::fmt_t s1_src;
  pfc_pkg::fmt_t s1_dst;
  logic [7:0]    s1_c0;
  logic [7:0]    s1_c1;
  logic [7:0]    s1_c2;
  logic [7:0]    s1_c3;
  logic [7:0]    s1_alpha;
  logic [15:0]   s1_m0;
  logic [15:0]   s1_m1;
  logic [15:0]   s1_m2;
  logic [23:0]   s1_lr;
  logic [23:0]   s1_lg;
  logic [23:0]   s1_lb;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_src   <= source_format;
      s1_dst   <= target_format;
      s1_c0    <= in_chan0;
      s1_c1    <= in_chan1;
      s1_c2    <= in_chan2;
      s1_c3    <= in_chan3;
      s1_alpha <= in_alpha;
      s1_m0    <= 16'(in_chan0) * 16'(in_alpha);
      s1_m1    <= 16'(in_chan1) * 16'(in_alpha);
      s1_m2    <= 16'(in_chan2) * 16'(in_alpha);
      s1_lr    <= 24'(in_chan0) * 24'(pfc_pkg::LUMA_WR);
      s1_lg    <= 24'(in_chan1) * 24'(pfc_pkg::LUMA_WG);
      s1_lb    <= 24'(in_chan2) * 24'(pfc_pkg::LUMA_WB);
    end
  end

  // stage 2: luma sum, truncated, and premultiplied colour
  logic [24:0] luma_sum;
  assign luma_sum = 25'(s1_lr) + 25'(s1_lg) + 25'(s1_lb);

  pfc_pkg::fmt_t s2_src;
  pfc_pkg::fmt_t s2_dst;
  logic [7:0]    s2_c0;
  logic [7:0]    s2_c1;
  logic [7:0]    s2_c2;
  logic [7:0]    s2_c3;
  logic [7:0]    s2_alpha;
  logic [7:0]    s2_luma;
  logic [7:0]    s2_p0;
  logic [7:0]    s2_p1;
  logic [7:0]    s2_p2;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_src   <= s1_src;
      s2_dst   <= s1_dst;
      s2_c0    <= s1_c0;
      s2_c1    <= s1_c1;
      s2_c2    <= s1_c2;
      s2_c3    <= s1_c3;
      s2_alpha <= s1_alpha;
      s2_luma  <= luma_sum[23:16];
      s2_p0    <= pfc_pkg::div255(s1_m0);
      s2_p1    <= pfc_pkg::div255(s1_m1);
      s2_p2    <= pfc_pkg::div255(s1_m2);
    end
  end

  // stage 3: luma times alpha, needed only for rgba to l
  pfc_pkg::fmt_t s3_src;
  pfc_pkg::fmt_t s3_dst;
  logic [7:0]    s3_c0;
  logic [7:0]    s3_c1;
  logic [7:0]    s3_c2;
  logic [7:0]    s3_c3;
  logic [7:0]    s3_alpha;
  logic [7:0]    s3_luma;
  logic [7:0]    s3_p0;
  logic [7:0]    s3_p1;
  logic [7:0]    s3_p2;
  logic [15:0]   s3_ya;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_src   <= s2_src;
      s3_dst   <= s2_dst;
      s3_c0    <= s2_c0;
      s3_c1    <= s2_c1;
      s3_c2    <= s2_c2;
      s3_c3    <= s2_c3;
      s3_alpha <= s2_alpha;
      s3_luma  <= s2_luma;
      s3_p0    <= s2_p0;
      s3_p1    <= s2_p1;
      s3_p2    <= s2_p2;
      s3_ya    <= 16'(s2_luma) * 16'(s2_alpha);
    end
  end

  // stage 4: final divide and per-format channel select
  logic [7:0] ya_div;
  logic [7:0] sel0;
  logic [7:0] sel1;
  logic [7:0] sel2;
  logic [7:0] sel3;
  logic       sel_err;

  assign ya_div = pfc_pkg::div255(s3_ya);

  always_comb begin
    sel0    = '0;
    sel1    = '0;
    sel2    = '0;
    sel3    = '0;
    sel_err = 1'b0;
    if (s3_src == s3_dst) begin
      // pass through, unused channels cleared
      sel_err = 1'b1;
      sel0    = s3_c0;
      if (s3_dst != pfc_pkg::FMT_L) begin
        sel1 = s3_c1;
      end
      if (s3_dst == pfc_pkg::FMT_RGB || s3_dst == pfc_pkg::FMT_RGBA) begin
        sel2 = s3_c2;
      end
      if (s3_dst == pfc_pkg::FMT_RGBA) begin
        sel3 = s3_c3;
      end
    end else begin
      case (s3_src)
        pfc_pkg::FMT_L: begin
          sel0 = s3_c0;
          if (s3_dst == pfc_pkg::FMT_LA) begin
            sel1 = pfc_pkg::FULL_ALPHA;
          end else begin
            sel1 = s3_c0;
            sel2 = s3_c0;
            if (s3_dst == pfc_pkg::FMT_RGBA) begin
              sel3 = pfc_pkg::FULL_ALPHA;
            end
          end
        end
        pfc_pkg::FMT_LA: begin
          if (s3_dst == pfc_pkg::FMT_RGBA) begin
            sel0 = s3_c0;
            sel1 = s3_c0;
            sel2 = s3_c0;
            sel3 = s3_c1;
          end else begin
            // alpha dropped: luma premultiplied
            sel0 = s3_p0;
            if (s3_dst == pfc_pkg::FMT_RGB) begin
              sel1 = s3_p0;
              sel2 = s3_p0;
            end
          end
        end
        pfc_pkg::FMT_RGB: begin
          if (s3_dst == pfc_pkg::FMT_RGBA) begin
            sel0 = s3_c0;
            sel1 = s3_c1;
            sel2 = s3_c2;
            sel3 = pfc_pkg::FULL_ALPHA;
          end else begin
            sel0 = s3_luma;
            if (s3_dst == pfc_pkg::FMT_LA) begin
              sel1 = pfc_pkg::FULL_ALPHA;
            end
          end
        end
        pfc_pkg::FMT_RGBA: begin
          if (s3_dst == pfc_pkg::FMT_L) begin
            sel0 = ya_div;
          end else if (s3_dst == pfc_pkg::FMT_LA) begin
            sel0 = s3_luma;
            sel1 = s3_alpha;
          end else begin
            sel0 = s3_p0;
            sel1 = s3_p1;
            sel2 = s3_p2;
          end
        end
        default: begin
          sel0 = s3_c0;
        end
      endcase
    end
  end

  // output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      out_chan0         <= sel0;
      out_chan1         <= sel1;
      out_chan2         <= sel2;
      out_chan3         <= sel3;
      channel_count     <= {1'b0, s3_dst} + 3'd1;
      same_format_error <= sel_err;
    end
  end

  assign out_valid = ctrl.valid[pfc_pkg::NUM_STAGES-1];

  // checks

  // input backs up only when every stage is full and the output is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (ctrl.valid == '1) && !out_ready)
    else $error("in_ready low with room in the pipeline");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // alpha channel only carries data for a four-channel target
  a_chan3_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_count != 3'd4 |-> out_chan3 == 8'd0)
    else $error("out_chan3 non-zero for a format without it");

  // blue only carries data for rgb or rgba targets
  a_chan2_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid && (channel_count == 3'd1 || channel_count == 3'd2) |-> out_chan2 == 8'd0)
    else $error("out_chan2 non-zero for a grey format");

endmodule

// ===== hdl/pfc_pipe_ctrl.sv =====
// valid tracking and per-stage load enables for the conversion pipeline
module pfc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output pfc_pkg::pipe_ctrl_t ctrl
);

  logic [pfc_pkg::NUM_STAGES-1:0] valid;
  logic [pfc_pkg::NUM_STAGES-1:0] valid_next;
  logic [pfc_pkg::NUM_STAGES-1:0] ready;

  // a slot may take new data when empty or when its word moves on
  always_comb begin
    ready[pfc_pkg::NUM_STAGES-1] = !valid[pfc_pkg::NUM_STAGES-1] || out_ready;
    for (int i = pfc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
    valid_next = valid;
    if (ready[0]) begin
      valid_next[0] = in_valid;
    end
    for (int i = 1; i < pfc_pkg::NUM_STAGES; i++) begin
      if (ready[i]) begin
        valid_next[i] = valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready   = ready[0];
  assign ctrl.load  = ready;
  assign ctrl.valid = valid;

endmodule

// ===== tb/pixel_format_convert_tb.sv =====
// self-checking testbench for the pixel format converter, directed table then random phases
module pixel_format_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // bt.709 luma weights in q0.16, kept apart from the design's own copy
  localparam int unsigned WEIGHT_R = 13933;
  localparam int unsigned WEIGHT_G = 46871;
  localparam int unsigned WEIGHT_B = 4732;
  localparam logic [7:0]  OPAQUE   = 8'd255;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;      // a little over the four-stage pipeline
  localparam int RANDOM_PHASES   = 24;
  localparam int WORDS_PER_PHASE = 78;
  localparam int MAX_IDLE        = 6;
  localparam int MAX_SHOWN       = 10;
  localparam int CYCLE_LIMIT     = 200000;

  // one pixel, four byte lanes
  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [7:0] ch3;
  } quad_t;

  // everything the block gives back for one word
  typedef struct packed {
    quad_t      chan;
    logic [2:0] count;
    logic       err;
  } pixel_out_t;

  // directed stimulus: formats, pixel, and a hand-written answer where it is obvious
  typedef struct packed {
    pfc_pkg::fmt_t src;
    pfc_pkg::fmt_t dst;
    quad_t         pix;
    logic          known;
    pixel_out_t    want;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;

  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    // straight after reset: rgb to rgba, alpha forced opaque
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_RGBA, '{8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd255}, 3'd4, 1'b0}},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_RGBA, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{'{8'd255, 8'd255, 8'd255, 8'd255}, 3'd4, 1'b0}},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_RGBA, '{8'd12,  8'd34,  8'd56,  8'd78},  1'b1,
      '{'{8'd12,  8'd34,  8'd56,  8'd255}, 3'd4, 1'b0}},
    // same format on both sides: flag up, unused lanes cleared
    '{pfc_pkg::FMT_L,    pfc_pkg::FMT_L,    '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{'{8'd255, 8'd0,   8'd0,   8'd0},   3'd1, 1'b1}},
    '{pfc_pkg::FMT_LA,   pfc_pkg::FMT_LA,   '{8'hA5,  8'h5A,  8'hFF,  8'hFF},  1'b1,
      '{'{8'hA5,  8'h5A,  8'd0,   8'd0},   3'd2, 1'b1}},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_RGB,  '{8'd1,   8'd2,   8'd3,   8'd4},   1'b1,
      '{'{8'd1,   8'd2,   8'd3,   8'd0},   3'd3, 1'b1}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGBA, '{8'd255, 8'd0,   8'd255, 8'd0},   1'b1,
      '{'{8'd255, 8'd0,   8'd255, 8'd0},   3'd4, 1'b1}},
    // luma fanned out, alpha added
    '{pfc_pkg::FMT_L,    pfc_pkg::FMT_LA,   '{8'd200, 8'd7,   8'd9,   8'd11},  1'b1,
      '{'{8'd200, 8'd255, 8'd0,   8'd0},   3'd2, 1'b0}},
    '{pfc_pkg::FMT_L,    pfc_pkg::FMT_RGB,  '{8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
      '{'{8'd255, 8'd255, 8'd255, 8'd0},   3'd3, 1'b0}},
    '{pfc_pkg::FMT_L,    pfc_pkg::FMT_RGBA, '{8'd0,   8'd255, 8'd255, 8'd255}, 1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd255}, 3'd4, 1'b0}},
    // la sources: alpha dropped at full and zero alpha, and kept for rgba
    '{pfc_pkg::FMT_LA,   pfc_pkg::FMT_L,    '{8'd255, 8'd255, 8'd0,   8'd0},   1'b1,
      '{'{8'd255, 8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_LA,   pfc_pkg::FMT_L,    '{8'd255, 8'd0,   8'd255, 8'd255}, 1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_LA,   pfc_pkg::FMT_RGB,  '{8'd100, 8'd128, 8'd3,   8'd4},   1'b0, '0},
    '{pfc_pkg::FMT_LA,   pfc_pkg::FMT_RGBA, '{8'd77,  8'd33,  8'd1,   8'd2},   1'b1,
      '{'{8'd77,  8'd77,  8'd77,  8'd33},  3'd4, 1'b0}},
    // luma extremes
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_L,    '{8'd255, 8'd255, 8'd255, 8'd0},   1'b1,
      '{'{8'd255, 8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_L,    '{8'd0,   8'd0,   8'd0,   8'd255}, 1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_LA,   '{8'd255, 8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{pfc_pkg::FMT_RGB,  pfc_pkg::FMT_LA,   '{8'd0,   8'd255, 8'd0,   8'd0},   1'b0, '0},
    // rgba sources, premultiplied where alpha goes away
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_L,    '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{'{8'd255, 8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_L,    '{8'd200, 8'd100, 8'd50,  8'd0},   1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   3'd1, 1'b0}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_LA,   '{8'd0,   8'd0,   8'd255, 8'd17},  1'b0, '0},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_LA,   '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{'{8'd255, 8'd255, 8'd0,   8'd0},   3'd2, 1'b0}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGB,  '{8'd255, 8'd255, 8'd255, 8'd0},   1'b1,
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   3'd3, 1'b0}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGB,  '{8'd200, 8'd100, 8'd50,  8'd255}, 1'b1,
      '{'{8'd200, 8'd100, 8'd50,  8'd0},   3'd3, 1'b0}},
    '{pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGB,  '{8'd128, 8'd64,  8'd32,  8'd128}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_we    = 1'b0;
  logic [pfc_pkg::REG_IDX_W-1:0] cfg_index = pfc_pkg::REG_SOURCE;
  logic [1:0]                    cfg_data  = 2'd0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_chan0 = 8'd0;
  logic [7:0] in_chan1 = 8'd0;
  logic [7:0] in_chan2 = 8'd0;
  logic [7:0] in_chan3 = 8'd0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_chan0;
  logic [7:0] out_chan1;
  logic [7:0] out_chan2;
  logic [7:0] out_chan3;
  logic [2:0] channel_count;
  logic       same_format_error;

  pixel_format_convert u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_chan0          (in_chan0),
    .in_chan1          (in_chan1),
    .in_chan2          (in_chan2),
    .in_chan3          (in_chan3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chan0         (out_chan0),
    .out_chan1         (out_chan1),
    .out_chan2         (out_chan2),
    .out_chan3         (out_chan3),
    .channel_count     (channel_count),
    .same_format_error (same_format_error)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // formats as the block should currently hold them, reset values to start
  pfc_pkg::fmt_t cur_src = pfc_pkg::FMT_RGB;
  pfc_pkg::fmt_t cur_dst = pfc_pkg::FMT_RGBA;

  // idling switches per phase; the result side reads out_idle for every word
  logic in_idle  = 1'b1;
  logic out_idle = 1'b1;

  pixel_out_t expected_pixels [$];

  int pixels_sent    = 0;
  int pixels_checked = 0;
  int settings_used  = 0;
  int n_errors       = 0;
  int cycle_count    = 0;

  // weighted sum of the three colours, truncated back to a byte
  function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned acc;
    acc = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
    return 8'(acc >> 16);
  endfunction

  // colour times alpha over 255, rounding down
  function automatic logic [7:0] scale_by_alpha(logic [7:0] v, logic [7:0] a);
    int unsigned prod;
    prod = v * a;
    return 8'(prod / 255);
  endfunction

  // what the converter should give for one pixel under the given formats
  function automatic pixel_out_t convert_pixel(pfc_pkg::fmt_t src, pfc_pkg::fmt_t dst,
                                               quad_t p);
    pixel_out_t r;
    logic [7:0] y;
    r       = '0;
    r.count = {1'b0, dst} + 3'd1;
    if (src == dst) begin
      // pass-through, lanes the format does not use stay at zero
      r.err     = 1'b1;
      r.chan.ch0 = p.ch0;
      if (dst != pfc_pkg::FMT_L) r.chan.ch1 = p.ch1;
      if (dst == pfc_pkg::FMT_RGB || dst == pfc_pkg::FMT_RGBA) r.chan.ch2 = p.ch2;
      if (dst == pfc_pkg::FMT_RGBA) r.chan.ch3 = p.ch3;
    end else begin
      case (src)
        pfc_pkg::FMT_L: begin
          r.chan.ch0 = p.ch0;
          if (dst == pfc_pkg::FMT_LA) begin
            r.chan.ch1 = OPAQUE;
          end else begin
            r.chan.ch1 = p.ch0;
            r.chan.ch2 = p.ch0;
            if (dst == pfc_pkg::FMT_RGBA) r.chan.ch3 = OPAQUE;
          end
        end
        pfc_pkg::FMT_LA: begin
          if (dst == pfc_pkg::FMT_RGBA) begin
            r.chan = '{p.ch0, p.ch0, p.ch0, p.ch1};
          end else begin
            y          = scale_by_alpha(p.ch0, p.ch1);
            r.chan.ch0 = y;
            if (dst == pfc_pkg::FMT_RGB) begin
              r.chan.ch1 = y;
              r.chan.ch2 = y;
            end
          end
        end
        pfc_pkg::FMT_RGB: begin
          if (dst == pfc_pkg::FMT_RGBA) begin
            r.chan = '{p.ch0, p.ch1, p.ch2, OPAQUE};
          end else begin
            r.chan.ch0 = luma_of(p.ch0, p.ch1, p.ch2);
            if (dst == pfc_pkg::FMT_LA) r.chan.ch1 = OPAQUE;
          end
        end
        default: begin
          // rgba source
          if (dst == pfc_pkg::FMT_L) begin
            r.chan.ch0 = scale_by_alpha(luma_of(p.ch0, p.ch1, p.ch2), p.ch3);
          end else if (dst == pfc_pkg::FMT_LA) begin
            r.chan.ch0 = luma_of(p.ch0, p.ch1, p.ch2);
            r.chan.ch1 = p.ch3;
          end else begin
            r.chan.ch0 = scale_by_alpha(p.ch0, p.ch3);
            r.chan.ch1 = scale_by_alpha(p.ch1, p.ch3);
            r.chan.ch2 = scale_by_alpha(p.ch2, p.ch3);
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned idle_cycles(logic enabled);
    return enabled ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  // random byte leaning towards the two extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // present one word, hold it until taken, then queue its expected result;
  // entered and left at a rising edge
  task automatic send_pixel(input quad_t p, input pixel_out_t want);
    int unsigned gap;
    logic        took;
    gap = idle_cycles(in_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chan0 <= p.ch0;
    in_chan1 <= p.ch1;
    in_chan2 <= p.ch2;
    in_chan3 <= p.ch3;
    // ready is sampled mid-cycle, away from the edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    expected_pixels.push_back(want);
    pixels_sent++;
  endtask

  // stop sending and let every word in flight come out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers on consecutive edges, write enable held across them
  task automatic set_formats(input pfc_pkg::fmt_t s, input pfc_pkg::fmt_t d);
    cfg_we    <= 1'b1;
    cfg_index <= pfc_pkg::REG_SOURCE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= pfc_pkg::REG_TARGET;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_src = s;
    cur_dst = d;
    settings_used++;
  endtask

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("pixel_format_convert_tb: errors");
      $finish;
    end
  end

  // result side: random back-pressure, each taken word checked against the oldest expectation
  initial begin : result_side
    int unsigned stall;
    logic        took;
    pixel_out_t  got;
    pixel_out_t  want;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = idle_cycles(out_idle);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        got  = '{'{out_chan0, out_chan1, out_chan2, out_chan3}, channel_count,
                 same_format_error};
        @(posedge clk);
      end while (!took);
      if (expected_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("unexpected word: %h %h %h %h count %0d flag %0b", got.chan.ch0,
                   got.chan.ch1, got.chan.ch2, got.chan.ch3, got.count, got.err);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.chan.ch0 !== want.chan.ch0 || got.chan.ch1 !== want.chan.ch1 ||
            got.chan.ch2 !== want.chan.ch2 || got.chan.ch3 !== want.chan.ch3 ||
            got.count !== want.count || got.err !== want.err) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN) begin
            $display("mismatch on result %0d: want %h %h %h %h count %0d flag %0b",
                     pixels_checked, want.chan.ch0, want.chan.ch1, want.chan.ch2,
                     want.chan.ch3, want.count, want.err);
            $display("  got %h %h %h %h count %0d flag %0b", got.chan.ch0,
                     got.chan.ch1, got.chan.ch2, got.chan.ch3, got.count, got.err);
          end
        end
      end
    end
  end

  // stimulus: reset, directed table, then random phases over all format pairs
  initial begin : stimulus
    directed_row_t row;
    pixel_out_t    want;
    quad_t         pix;
    pfc_pkg::fmt_t s;
    pfc_pkg::fmt_t d;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words: first rows run on the reset formats, no register write
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.src != cur_src || row.dst != cur_dst) begin
        drain_pipeline();
        set_formats(row.src, row.dst);
      end
      want = row.known ? row.want : convert_pixel(row.src, row.dst, row.pix);
      send_pixel(row.pix, want);
    end

    // random phases: the first sixteen walk every source and target pair, the rest pick freely;
    // idling cycles through none, sender only, receiver only and both
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_pipeline();
      if (ph < 16) begin
        s = pfc_pkg::fmt_t'(ph / 4);
        d = pfc_pkg::fmt_t'(ph % 4);
      end else begin
        s = pfc_pkg::fmt_t'($urandom_range(0, 3));
        d = pfc_pkg::fmt_t'($urandom_range(0, 3));
      end
      in_idle  = ph[0];
      out_idle = ph[1];
      set_formats(s, d);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pix = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_pixel(pix, convert_pixel(cur_src, cur_dst, pix));
      end
    end

    // everything sent; wait for the tail, then a few spare cycles for stray words
    drain_pipeline();

    $display("run summary: %0d pixels in, %0d results checked, %0d format writes",
             pixels_sent, pixels_checked, settings_used);
    $display("every source/target pair seen, with and without idling on either side");
    if (n_errors == 0) begin
      $display("pixel_format_convert_tb: clean");
    end else begin
      $display("%0d failing results", n_errors);
      $display("pixel_format_convert_tb: errors");
    end
    $finish;
  end

endmodule
